// ===== design/spnc_pkg.sv =====
// ----------------------------------------------------------------------------
// spnc_pkg
// Shared types, note table and boundary ladder for the spectral peak
// note classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package spnc_pkg;

	localparam int PosW  = 27;	// refined position times pair sum, clamped at zero
	localparam int DenW  = 16;	// neighbor plus peak magnitude
	localparam int FreqW = 16;
	localparam int IdxW  = 6;
	localparam int RemW  = 36;	// divider remainder, below den * 2^20
	localparam int ProdW = 43;
	localparam int NoteW = 18;
	localparam int ZoneW = 3;
	localparam int MaxNotes = 64;

	localparam logic [ZoneW-1:0] ZoneNone = 3'd0;
	localparam logic [ZoneW-1:0] Zone1    = 3'd1;
	localparam logic [ZoneW-1:0] Zone2    = 3'd2;
	localparam logic [ZoneW-1:0] Zone3    = 3'd3;
	localparam logic [ZoneW-1:0] Zone4    = 3'd4;

	localparam logic [63:0] LadderBase   = 64'd274349425;
	localparam logic [63:0] LadderOffset = 64'd1104744079;
	localparam logic [63:0] SemitoneQ30  = 64'd1137589840;
	localparam logic [63:0] Q30Half      = 64'd536870912;

	typedef struct packed {
		logic [PosW-1:0] pos;
		logic [DenW-1:0] den;
		logic            mag_zero;
	} spnc_item_t;

	// Note frequencies in Hz*64
	function automatic logic [NoteW-1:0] note_freq(input logic [IdxW-1:0] idx);
		logic [NoteW-1:0] v;
		case (idx)
			6'd0:  v = 18'd4186;   6'd1:  v = 18'd4435;   6'd2:  v = 18'd4699;
			6'd3:  v = 18'd4979;   6'd4:  v = 18'd5274;   6'd5:  v = 18'd5588;
			6'd6:  v = 18'd5920;   6'd7:  v = 18'd6272;   6'd8:  v = 18'd6645;
			6'd9:  v = 18'd7041;   6'd10: v = 18'd7459;   6'd11: v = 18'd7903;
			6'd12: v = 18'd8372;   6'd13: v = 18'd8870;   6'd14: v = 18'd9398;
			6'd15: v = 18'd9956;   6'd16: v = 18'd10548;  6'd17: v = 18'd11176;
			6'd18: v = 18'd11841;  6'd19: v = 18'd12545;  6'd20: v = 18'd13290;
			6'd21: v = 18'd14081;  6'd22: v = 18'd14918;  6'd23: v = 18'd15805;
			6'd24: v = 18'd16745;  6'd25: v = 18'd17741;  6'd26: v = 18'd18796;
			6'd27: v = 18'd19913;  6'd28: v = 18'd21098;  6'd29: v = 18'd22352;
			6'd30: v = 18'd23681;  6'd31: v = 18'd25089;  6'd32: v = 18'd26581;
			6'd33: v = 18'd28161;  6'd34: v = 18'd29836;  6'd35: v = 18'd31610;
			6'd36: v = 18'd33488;  6'd37: v = 18'd35480;  6'd38: v = 18'd37589;
			6'd39: v = 18'd39824;  6'd40: v = 18'd42193;  6'd41: v = 18'd44701;
			6'd42: v = 18'd47359;  6'd43: v = 18'd50175;  6'd44: v = 18'd53159;
			6'd45: v = 18'd56320;  6'd46: v = 18'd59669;  6'd47: v = 18'd63217;
			6'd48: v = 18'd66976;  6'd49: v = 18'd70959;  6'd50: v = 18'd75178;
			6'd51: v = 18'd79649;  6'd52: v = 18'd84385;  6'd53: v = 18'd89402;
			6'd54: v = 18'd94719;  6'd55: v = 18'd100351; 6'd56: v = 18'd106318;
			6'd57: v = 18'd112640; 6'd58: v = 18'd119338; 6'd59: v = 18'd126434;
			6'd60: v = 18'd133952; 6'd61: v = 18'd141917; 6'd62: v = 18'd150356;
			6'd63: v = 18'd159297;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

	// Upper boundary of note n in Hz*64*65536; evaluated at elaboration only
	function automatic logic [63:0] ladder_bound(input int n);
		logic [63:0] b;
		b = (LadderBase * LadderOffset + Q30Half) >> 30;
		for (int i = 0; i < n; i++) begin
			b = (b * SemitoneQ30 + Q30Half) >> 30;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== design/spnc_front.sv =====
// ----------------------------------------------------------------------------
// spnc_front
// Accepts a peak item, picks the larger neighbor and forms the Grandke
// position numerator and pair sum for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module spnc_front import spnc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [9:0]       peak_bin,
	input  wire logic [14:0]      mag_below,
	input  wire logic [14:0]      mag_peak,
	input  wire logic [14:0]      mag_above,
	output logic                  push,
	output spnc_item_t            push_item,
	input  wire logic             queue_full
);

	logic            up;
	logic [14:0]     m2;
	logic [DenW-1:0] den;
	logic [18:0]     num;
	logic [25:0]     kd;
	logic [27:0]     pos;
	spnc_item_t      item_c;
	spnc_item_t      item_s1;
	logic            vld_s1;
	logic            adv;

	always_comb begin
		up  = mag_above > mag_below;
		m2  = up ? mag_above : mag_below;
		den = {1'b0, m2} + {1'b0, mag_peak};
		num = {3'b0, m2, 1'b0} - {4'b0, mag_peak};
		kd  = {16'b0, peak_bin} * {10'b0, den};
		pos = up ? ({2'b0, kd} + {{9{num[18]}}, num})
		         : ({2'b0, kd} - {{9{num[18]}}, num});
		item_c.mag_zero = (mag_peak == 15'd0);
		if (item_c.mag_zero) begin
			item_c.pos = {{(PosW-10){1'b0}}, peak_bin};
			item_c.den = 16'd1;
		end else begin
			// clamp a position at or below zero to zero: freq then rounds to 0
			item_c.pos = (pos[27] || pos == 28'd0) ? '0 : pos[PosW-1:0];
			item_c.den = den;
		end
	end

	assign push      = vld_s1 && !queue_full;
	assign adv       = !vld_s1 || push;
	assign in_stall  = !adv;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

`default_nettype wire

// ===== design/spnc_queue.sv =====
// ----------------------------------------------------------------------------
// spnc_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module spnc_queue import spnc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  spnc_item_t      push_item,
	output logic            full,
	input  wire logic       pop,
	output spnc_item_t      pop_item,
	output logic            empty
);

	spnc_item_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== design/spnc_back.sv =====
// ----------------------------------------------------------------------------
// spnc_back
// Scales the position by the bin width, divides through a pipelined
// restoring divider, finds the nearest note and grades the distance zone.
// ----------------------------------------------------------------------------
`default_nettype none

module spnc_back import spnc_pkg::*; #(
	parameter int NOTE_COUNT = 36
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  spnc_item_t            item,
	input  wire logic             item_valid,
	output logic                  pop,
	input  wire logic [15:0]      bin_width,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [FreqW-1:0]      freq_est,
	output logic [IdxW-1:0]       note_num,
	output logic                  sharp,
	output logic [ZoneW-1:0]      zone,
	output logic                  out_of_range
);

	localparam int NC = (NOTE_COUNT > MaxNotes) ? MaxNotes : ((NOTE_COUNT < 3) ? 3 : NOTE_COUNT);
	localparam int Steps = FreqW;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NC - 1);

	logic adv;

	// stage 1: multiply
	logic [ProdW-1:0] prod_s1;
	logic [DenW-1:0]  den_s1;
	logic             mz_s1;
	logic             vld_s1;

	// divider steps, element 0 holds the rounded dividend
	logic [RemW-1:0]  rem_s2 [Steps+1];
	logic [FreqW-1:0] quo_s2 [Steps+1];
	logic [DenW-1:0]  den_s2 [Steps+1];
	logic             sat_s2 [Steps+1];
	logic             mz_s2  [Steps+1];
	logic             vld_s2 [Steps+1];
	logic [RemW-1:0]  rem_nx [Steps];
	logic [FreqW-1:0] quo_nx [Steps];

	logic [43:0]      dividend;
	logic             sat_c;

	// note search
	logic [FreqW-1:0] freq_s3;
	logic             mz_s3;
	logic             vld_s3;
	logic [NC-2:0]    ge;
	logic [IdxW-1:0]  idx_c;

	logic [FreqW-1:0] freq_s4;
	logic [IdxW-1:0]  idx_s4;
	logic             mz_s4;
	logic             vld_s4;

	// zone grading
	logic [21:0] fv, nv, uv, dv, za, zb, zc;
	logic [22:0] sum_b, sum_a, sum_c;
	logic        sharp_c;
	logic [ZoneW-1:0] zone_c;
	logic        oor_c;

	assign adv = !(out_valid && out_stall);
	assign pop = adv && item_valid;

	always_comb begin
		dividend = {1'b0, prod_s1} + {25'b0, den_s1, 3'b0};
		sat_c    = dividend >= {8'b0, den_s1, 20'b0};
	end

	for (genvar j = 0; j < Steps; j++) begin : g_div
		logic [RemW-1:0] trial;
		logic            fit;
		always_comb begin
			trial     = {{(RemW-DenW){1'b0}}, den_s2[j]} << (4 + Steps - 1 - j);
			fit       = rem_s2[j] >= trial;
			rem_nx[j] = fit ? rem_s2[j] - trial : rem_s2[j];
			quo_nx[j] = {quo_s2[j][FreqW-2:0], fit};
		end
	end

	for (genvar g = 0; g < NC - 1; g++) begin : g_ladder
		localparam logic [63:0] Bound = ladder_bound(g);
		assign ge[g] = {32'b0, freq_s3, 16'b0} >= Bound;
	end

	// boundaries rise with the index, so the highest passed one gives the note
	always_comb begin
		idx_c = '0;
		for (int g = 0; g < NC - 1; g++) begin
			if (ge[g]) begin
				idx_c = IdxW'(g + 1);
			end
		end
	end

	always_comb begin
		fv    = {3'b0, freq_s4, 3'b0};
		nv    = {1'b0, note_freq(idx_s4), 3'b0};
		uv    = ({4'b0, note_freq(idx_s4 + 6'd1)} + {4'b0, note_freq(idx_s4)}) << 2;
		dv    = ({4'b0, note_freq(idx_s4 - 6'd1)} + {4'b0, note_freq(idx_s4)}) << 2;
		oor_c = mz_s4 || (idx_s4 == '0) || (idx_s4 >= LastIdx);
		sharp_c = 1'b0;
		zone_c  = ZoneNone;
		if (fv < nv) begin
			sum_b = {1'b0, dv} + {1'b0, nv};
			zb    = sum_b[22:1];
			sum_a = {1'b0, dv} + {1'b0, zb};
			za    = sum_a[22:1];
			sum_c = {1'b0, zb} + {1'b0, nv};
			zc    = sum_c[22:1];
			if (fv <= za)      zone_c = Zone4;
			else if (fv <= zb) zone_c = Zone3;
			else if (fv <= zc) zone_c = Zone2;
			else               zone_c = Zone1;
		end else begin
			sum_b = {1'b0, nv} + {1'b0, uv};
			zb    = sum_b[22:1];
			sum_a = {1'b0, nv} + {1'b0, zb};
			za    = sum_a[22:1];
			sum_c = {1'b0, zb} + {1'b0, uv};
			zc    = sum_c[22:1];
			sharp_c = 1'b1;
			if (fv < za)      zone_c = Zone1;
			else if (fv < zb) zone_c = Zone2;
			else if (fv < zc) zone_c = Zone3;
			else              zone_c = Zone4;
		end
		if (oor_c) begin
			sharp_c = 1'b0;
			zone_c  = ZoneNone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			for (int j = 0; j <= Steps; j++) begin
				vld_s2[j] <= 1'b0;
			end
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= item_valid;
			vld_s2[0] <= vld_s1;
			for (int j = 0; j < Steps; j++) begin
				vld_s2[j+1] <= vld_s2[j];
			end
			vld_s3    <= vld_s2[Steps];
			vld_s4    <= vld_s3;
			out_valid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= {{(ProdW-PosW){1'b0}}, item.pos} * {{(ProdW-16){1'b0}}, bin_width};
			den_s1    <= item.den;
			mz_s1     <= item.mag_zero;
			rem_s2[0] <= dividend[RemW-1:0];
			quo_s2[0] <= '0;
			den_s2[0] <= den_s1;
			sat_s2[0] <= sat_c;
			mz_s2[0]  <= mz_s1;
			for (int j = 0; j < Steps; j++) begin
				rem_s2[j+1] <= rem_nx[j];
				quo_s2[j+1] <= quo_nx[j];
				den_s2[j+1] <= den_s2[j];
				sat_s2[j+1] <= sat_s2[j];
				mz_s2[j+1]  <= mz_s2[j];
			end
			freq_s3      <= sat_s2[Steps] ? '1 : quo_s2[Steps];
			mz_s3        <= mz_s2[Steps];
			freq_s4      <= freq_s3;
			idx_s4       <= mz_s3 ? '0 : idx_c;
			mz_s4        <= mz_s3;
			freq_est     <= freq_s4;
			note_num     <= idx_s4;
			sharp        <= sharp_c;
			zone         <= zone_c;
			out_of_range <= oor_c;
		end
	end

endmodule

`default_nettype wire

// ===== design/spectral_peak_note_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// spectral_peak_note_classifier_unit
// Grandke peak interpolation followed by nearest-note and zone grading.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   in       | in_valid / in_stall | peak_bin, mag_below, mag_peak, mag_above
//   out      | out_valid/out_stall | freq_est, note_num, sharp, zone,
//            |                     | out_of_range
//   cfg      | cfg_valid/cfg_ready | cfg_data (bin_width)
//
// One item per cycle unless the output stalls, through one front register,
// one queue slot, then multiply, 17 divider registers (one quotient bit per
// step), the saturated quotient, note search and the output register.
// Reset empties the pipeline and the queue and sets bin_width to 2560.
// An output stall freezes the back part; the queue keeps the front taking
// items until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_peak_note_classifier_unit import spnc_pkg::*; #(
	parameter int NOTE_COUNT = 36
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [9:0]  peak_bin,
	input  wire logic [14:0] mag_below,
	input  wire logic [14:0] mag_peak,
	input  wire logic [14:0] mag_above,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      freq_est,
	output logic [5:0]       note_num,
	output logic             sharp,
	output logic [2:0]       zone,
	output logic             out_of_range,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] bin_width_q;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	spnc_item_t  push_item;
	spnc_item_t  pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= 16'd2560;
		end else if (cfg_valid && cfg_ready) begin
			bin_width_q <= cfg_data;
		end
	end

	spnc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.peak_bin   (peak_bin),
		.mag_below  (mag_below),
		.mag_peak   (mag_peak),
		.mag_above  (mag_above),
		.push       (push),
		.push_item  (push_item),
		.queue_full (full)
	);

	spnc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	spnc_back #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (pop_item),
		.item_valid   (!empty),
		.pop          (pop),
		.bin_width    (bin_width_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.freq_est     (freq_est),
		.note_num     (note_num),
		.sharp        (sharp),
		.zone         (zone),
		.out_of_range (out_of_range)
	);

endmodule

`default_nettype wire
